// File: rtl/bilrgb_pkg.sv
// ----------------------------------------------------------------------------
// bilrgb_pkg: shared types and constants of the bilinear RGB scaler
// Payload structs, register indexes and frame store geometry.
// ----------------------------------------------------------------------------
`default_nettype none
package bilrgb_pkg;

   localparam int MAX_SRC_WIDTH  = 256;
   localparam int MAX_SRC_HEIGHT = 256;
   localparam int MAX_OUT_DIM    = 1024;

   localparam int COL_W  = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_W  = $clog2(MAX_SRC_HEIGHT);
   localparam int BANK_DEPTH = (MAX_SRC_WIDTH / 2) * (MAX_SRC_HEIGHT / 2);
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int PIX_W  = 24;
   localparam int CSR_W  = 24;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_X_STEP     = 2'd2,
      REG_Y_STEP     = 2'd3
   } reg_index_type;

   typedef enum logic {
      FUNC_WRITE   = 1'b0,
      FUNC_REQUEST = 1'b1
   } func_type;

   typedef struct packed {
      logic       func;
      logic [9:0] col;
      logic [9:0] row;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

endpackage
`default_nettype wire

// File: rtl/bilrgb_ram.sv
// ----------------------------------------------------------------------------
// bilrgb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bilrgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// File: rtl/bilrgb_lane.sv
// ----------------------------------------------------------------------------
// bilrgb_lane: one color channel of the bilinear blend
// Horizontal blend in the first stage, vertical blend and truncation in the
// second.
// ----------------------------------------------------------------------------
`default_nettype none
module bilrgb_lane (
   input  wire logic       clock,
   input  wire logic       adv,
   input  wire logic [7:0] p11,
   input  wire logic [7:0] p21,
   input  wire logic [7:0] p12,
   input  wire logic [7:0] p22,
   input  wire logic [7:0] fx,
   input  wire logic [7:0] fy,
   output logic      [7:0] result
);
   import bilrgb_pkg::*;

   logic [8:0]  inv_fx;
   logic [16:0] top_in, bot_in;
   logic [16:0] top_ff, bot_ff;
   logic [7:0]  fy_ff;
   logic [8:0]  inv_fy;
   logic [25:0] sum_in;
   logic [7:0]  result_ff;

   assign inv_fx = 9'd256 - {1'b0, fx};
   assign top_in = p11 * inv_fx + p21 * {1'b0, fx};
   assign bot_in = p12 * inv_fx + p22 * {1'b0, fx};

   assign inv_fy = 9'd256 - {1'b0, fy_ff};
   assign sum_in = top_ff * inv_fy + bot_ff * {1'b0, fy_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         fy_ff     <= fy;
         result_ff <= sum_in[23:16];
      end
   end

   assign result = result_ff;
endmodule
`default_nettype wire

// File: rtl/bilinear_rgb_scaler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_rgb_scaler_unit: bilinear RGB888 scaler with banked frame store
//
// The req channel carries source pixel writes (func write) and output pixel
// requests (func request). A write stores one pixel and gives no response; a
// write outside the source size is dropped. A request returns one
// interpolated pixel on the rsp channel, in request order.
// The csr port sets source width, height and the 8.16 x/y steps; write it
// only while the block is idle.
// Throughput: one item per cycle while the receiver does not stall. The
// frame store is split into four banks by column and row parity, so the
// four neighbors of a request are read in the same cycle. A request passes
// the registered multiply, bank read, horizontal and vertical blend stages.
// When the receiver stalls, the whole pipeline holds and req_ready drops.
// Reset clears the pipeline valids and loads the size and step registers
// with 256, 256, 1.0, 1.0; frame store contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
module bilinear_rgb_scaler_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire bilrgb_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output bilrgb_pkg::rsp_type       rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [23:0]          csr_wdata
);
   import bilrgb_pkg::*;

   logic [8:0]  src_width_ff, src_height_ff;
   logic [23:0] x_step_ff, y_step_ff;

   logic        adv;
   logic        accept;

   // effective sizes
   logic [8:0]  w_eff, h_eff;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;

   // stage 1
   logic        s1_req_ff, s1_we_ff;
   logic [33:0] s1_px_ff, s1_py_ff;
   logic [COL_W-1:0] s1_wcol_ff;
   logic [ROW_W-1:0] s1_wrow_ff;
   logic [PIX_W-1:0] s1_wdata_ff;
   logic        s1_we_in;

   logic [17:0] ipx, ipy;
   logic [18:0] ipx1, ipy1;
   logic [COL_W-1:0] x1, x2;
   logic [ROW_W-1:0] y1, y2;

   // stage 2
   logic        s2_req_ff;
   logic        s2_x1p_ff, s2_x2p_ff, s2_y1p_ff, s2_y2p_ff;
   logic [7:0]  s2_fx_ff, s2_fy_ff;
   logic [PIX_W-1:0] bank_rd [4];

   // stage 3, 4
   logic        s3_req_ff, s4_req_ff;
   logic [PIX_W-1:0] p11, p21, p12, p22;
   rsp_type     lane_out;

   assign adv       = !s4_req_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd256;
         src_height_ff <= 9'd256;
         x_step_ff     <= 24'd65536;
         y_step_ff     <= 24'd65536;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_SRC_WIDTH:  src_width_ff  <= csr_wdata[8:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_wdata[8:0];
            REG_X_STEP:     x_step_ff     <= csr_wdata;
            REG_Y_STEP:     y_step_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (src_width_ff == 9'd0) begin
         w_eff = 9'd1;
      end else if (src_width_ff > 9'(MAX_SRC_WIDTH)) begin
         w_eff = 9'(MAX_SRC_WIDTH);
      end else begin
         w_eff = src_width_ff;
      end
      if (src_height_ff == 9'd0) begin
         h_eff = 9'd1;
      end else if (src_height_ff > 9'(MAX_SRC_HEIGHT)) begin
         h_eff = 9'(MAX_SRC_HEIGHT);
      end else begin
         h_eff = src_height_ff;
      end
   end

   assign w_last = COL_W'(w_eff - 9'd1);
   assign h_last = ROW_W'(h_eff - 9'd1);

   assign s1_we_in = accept && (req_data.func == FUNC_WRITE)
                     && (req_data.col < {1'b0, w_eff})
                     && (req_data.row < {1'b0, h_eff});

   // stage 1: position multiply, hold write
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_req_ff <= 1'b0;
         s1_we_ff  <= 1'b0;
      end else if (adv) begin
         s1_req_ff <= accept && (req_data.func == FUNC_REQUEST);
         s1_we_ff  <= s1_we_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_px_ff    <= req_data.col * x_step_ff;
         s1_py_ff    <= req_data.row * y_step_ff;
         s1_wcol_ff  <= req_data.col[COL_W-1:0];
         s1_wrow_ff  <= req_data.row[ROW_W-1:0];
         s1_wdata_ff <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   // clamp neighbors to the source edge
   assign ipx  = s1_px_ff[33:16];
   assign ipy  = s1_py_ff[33:16];
   assign ipx1 = {1'b0, ipx} + 19'd1;
   assign ipy1 = {1'b0, ipy} + 19'd1;
   assign x1 = (ipx  < 18'(w_last)) ? ipx[COL_W-1:0]  : w_last;
   assign x2 = (ipx1 < 19'(w_last)) ? ipx1[COL_W-1:0] : w_last;
   assign y1 = (ipy  < 18'(h_last)) ? ipy[ROW_W-1:0]  : h_last;
   assign y2 = (ipy1 < 19'(h_last)) ? ipy1[ROW_W-1:0] : h_last;

   // four banks indexed by {row parity, column parity}
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [COL_W-1:0] cx;
      logic [ROW_W-1:0] ry;
      logic             wr_en;
      logic [BANK_AW-1:0] rd_addr, wr_addr;

      assign cx = (x1[0] == 1'(b % 2)) ? x1 : x2;
      assign ry = (y1[0] == 1'(b / 2)) ? y1 : y2;
      assign rd_addr = {ry[ROW_W-1:1], cx[COL_W-1:1]};
      assign wr_addr = {s1_wrow_ff[ROW_W-1:1], s1_wcol_ff[COL_W-1:1]};
      assign wr_en = adv && s1_we_ff && (s1_wcol_ff[0] == 1'(b % 2))
                     && (s1_wrow_ff[0] == 1'(b / 2));

      bilrgb_ram #(
         .WIDTH (PIX_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (s1_wdata_ff),
         .rd_en   (adv),
         .rd_addr (rd_addr),
         .rd_data (bank_rd[b])
      );
   end

   // stage 2: bank data arrives
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_req_ff <= 1'b0;
         s3_req_ff <= 1'b0;
         s4_req_ff <= 1'b0;
      end else if (adv) begin
         s2_req_ff <= s1_req_ff;
         s3_req_ff <= s2_req_ff;
         s4_req_ff <= s3_req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x1p_ff <= x1[0];
         s2_x2p_ff <= x2[0];
         s2_y1p_ff <= y1[0];
         s2_y2p_ff <= y2[0];
         s2_fx_ff  <= s1_px_ff[15:8];
         s2_fy_ff  <= s1_py_ff[15:8];
      end
   end

   // route bank outputs to neighbor positions; a clamped pair shares one bank
   assign p11 = bank_rd[{s2_y1p_ff, s2_x1p_ff}];
   assign p21 = bank_rd[{s2_y1p_ff, s2_x2p_ff}];
   assign p12 = bank_rd[{s2_y2p_ff, s2_x1p_ff}];
   assign p22 = bank_rd[{s2_y2p_ff, s2_x2p_ff}];

   bilrgb_lane u_lane_red (
      .clock (clock), .adv (adv),
      .p11 (p11[23:16]), .p21 (p21[23:16]), .p12 (p12[23:16]), .p22 (p22[23:16]),
      .fx (s2_fx_ff), .fy (s2_fy_ff), .result (lane_out.red_out)
   );

   bilrgb_lane u_lane_green (
      .clock (clock), .adv (adv),
      .p11 (p11[15:8]), .p21 (p21[15:8]), .p12 (p12[15:8]), .p22 (p22[15:8]),
      .fx (s2_fx_ff), .fy (s2_fy_ff), .result (lane_out.green_out)
   );

   bilrgb_lane u_lane_blue (
      .clock (clock), .adv (adv),
      .p11 (p11[7:0]), .p21 (p21[7:0]), .p12 (p12[7:0]), .p22 (p22[7:0]),
      .fx (s2_fx_ff), .fy (s2_fy_ff), .result (lane_out.blue_out)
   );

   assign rsp_valid = s4_req_ff;
   assign rsp_data  = lane_out;
endmodule
`default_nettype wire

// File: dv/bilinear_rgb_scaler_unit_tb.sv
// ----------------------------------------------------------------------------
// bilinear_rgb_scaler_unit_tb: self-checking bench for the bilinear scaler
// Fills a source frame, then requests output pixels under several size and
// step settings. A local frame copy predicts every interpolated pixel, and
// the bench checks each response in order under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bilinear_rgb_scaler_unit_tb;
   import bilrgb_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 12;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_we;
   logic [1:0]    csr_index;
   logic [23:0]   csr_wdata;
   logic          req_taken;

   bilinear_rgb_scaler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [23:0]   frame_copy [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
   bit            frame_written [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
   logic [8:0]    cur_width;
   logic [8:0]    cur_height;
   logic [23:0]   cur_x_step;
   logic [23:0]   cur_y_step;

   req_type       pending_items[$];
   rsp_type       expected_pixels[$];

   int            send_idle_pct;
   int            stall_pct;
   int            hold_off_cycles;
   int            mismatch_count;
   int            accepted_items;
   int            pixels_checked;
   int            quiet_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int eff_dim(input logic [8:0] v, input int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // neighbor pair and 8-bit fraction of one axis
   function automatic void find_neighbors(input int pos, input logic [23:0] step,
                                          input int size,
                                          output int a, output int b, output int frac);
      longint unsigned p;
      longint unsigned ip;
      p = longint'(pos) * longint'(step);
      ip = p >> 16;
      frac = int'((p >> 8) & 8'hff);
      a = (ip < size - 1) ? int'(ip) : size - 1;
      b = (ip + 1 < size - 1) ? int'(ip + 1) : size - 1;
   endfunction

   function automatic bit pixels_defined(input int c, input int r);
      int w;
      int h;
      int x1, x2, y1, y2, fx, fy;
      w = eff_dim(cur_width, MAX_SRC_WIDTH);
      h = eff_dim(cur_height, MAX_SRC_HEIGHT);
      if (c >= MAX_OUT_DIM) c = MAX_OUT_DIM - 1;
      if (r >= MAX_OUT_DIM) r = MAX_OUT_DIM - 1;
      find_neighbors(c, cur_x_step, w, x1, x2, fx);
      find_neighbors(r, cur_y_step, h, y1, y2, fy);
      return frame_written[y1*MAX_SRC_WIDTH+x1] && frame_written[y1*MAX_SRC_WIDTH+x2] &&
             frame_written[y2*MAX_SRC_WIDTH+x1] && frame_written[y2*MAX_SRC_WIDTH+x2];
   endfunction

   // apply one accepted write to the frame copy, or queue the interpolated pixel of a request
   task automatic interpolate_item(input req_type it);
      int w;
      int h;
      int c;
      int r;
      int x1, x2, y1, y2, fx, fy;
      logic [23:0] p11, p21, p12, p22;
      int unsigned top, bot, v;
      logic [23:0] pix;
      w = eff_dim(cur_width, MAX_SRC_WIDTH);
      h = eff_dim(cur_height, MAX_SRC_HEIGHT);
      c = it.col;
      r = it.row;
      if (it.func == FUNC_WRITE) begin
         if (c < w && r < h) begin
            frame_copy[r*MAX_SRC_WIDTH+c] = {it.red_in, it.green_in, it.blue_in};
            frame_written[r*MAX_SRC_WIDTH+c] = 1'b1;
         end
         return;
      end
      if (c >= MAX_OUT_DIM) c = MAX_OUT_DIM - 1;
      if (r >= MAX_OUT_DIM) r = MAX_OUT_DIM - 1;
      find_neighbors(c, cur_x_step, w, x1, x2, fx);
      find_neighbors(r, cur_y_step, h, y1, y2, fy);
      p11 = frame_copy[y1*MAX_SRC_WIDTH+x1];
      p21 = frame_copy[y1*MAX_SRC_WIDTH+x2];
      p12 = frame_copy[y2*MAX_SRC_WIDTH+x1];
      p22 = frame_copy[y2*MAX_SRC_WIDTH+x2];
      for (int k = 0; k < 3; k++) begin
         top = p11[16-8*k +: 8] * (256 - fx) + p21[16-8*k +: 8] * fx;
         bot = p12[16-8*k +: 8] * (256 - fx) + p22[16-8*k +: 8] * fx;
         v = (top * (256 - fy) + bot * fy) >> 16;
         pix[16-8*k +: 8] = v[7:0];
      end
      expected_pixels.push_back(rsp_type'(pix));
   endtask

   // remember whether the last rising edge moved a transfer
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // a transfer happened on the last edge if valid and ready were high
         if (pending_items.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            interpolate_item(req_data);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected pixel %h at %0t", rsp_data, $realtime);
            end else begin
               rsp_type want;
               want = expected_pixels.pop_front();
               pixels_checked++;
               if (want.red_out !== rsp_data.red_out || want.green_out !== rsp_data.green_out
                   || want.blue_out !== rsp_data.blue_out) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("pixel mismatch: expected %h got %h", want, rsp_data);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("bilinear_rgb_scaler_unit_tb failed");
            $finish;
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [23:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_SRC_WIDTH:  cur_width  = val[8:0];
         REG_SRC_HEIGHT: cur_height = val[8:0];
         REG_X_STEP:     cur_x_step = val;
         REG_Y_STEP:     cur_y_step = val;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_items.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type make_item(input func_type f, input int c, input int r);
      req_type it;
      it.func     = f;
      it.col      = 10'(c);
      it.row      = 10'(r);
      it.red_in   = 8'($urandom_range(255, 0));
      it.green_in = 8'($urandom_range(255, 0));
      it.blue_in  = 8'($urandom_range(255, 0));
      return it;
   endfunction

   // request with random content, kept to neighbors that were written;
   // fall back to the origin, which every phase writes
   task automatic queue_request(input int c, input int r);
      if (!pixels_defined(c, r)) begin
         c = 0;
         r = 0;
      end
      pending_items.push_back(make_item(FUNC_REQUEST, c, r));
   endtask

   // fill a small frame corner and mark it in the predictor ahead of time:
   // writes are applied in order before later requests are checked
   task automatic fill_frame(input int w, input int h);
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            pending_items.push_back(make_item(FUNC_WRITE, c, r));
            frame_written[r*MAX_SRC_WIDTH+c] = 1'b1;
         end
   endtask

   task automatic run_phase(input int w, input int h, input logic [23:0] xs,
                            input logic [23:0] ys, input int n, input int idle, input int stall);
      int ew;
      int eh;
      write_reg(REG_SRC_WIDTH, 24'(w));
      write_reg(REG_SRC_HEIGHT, 24'(h));
      write_reg(REG_X_STEP, xs);
      write_reg(REG_Y_STEP, ys);
      send_idle_pct = idle;
      stall_pct = stall;
      ew = eff_dim(9'(w), MAX_SRC_WIDTH);
      eh = eff_dim(9'(h), MAX_SRC_HEIGHT);
      if (ew > 12) ew = 12;
      if (eh > 12) eh = 12;
      fill_frame(ew, eh);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9, 0))
            0: pending_items.push_back(make_item(FUNC_WRITE, $urandom_range(1023, 0),
                                                 $urandom_range(1023, 0)));
            1: pending_items.push_back(make_item(FUNC_WRITE, $urandom_range(ew - 1, 0),
                                                 $urandom_range(eh - 1, 0)));
            2: queue_request($urandom_range(1023, 0), $urandom_range(1023, 0));
            default: queue_request($urandom_range(15, 0), $urandom_range(15, 0));
         endcase
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      req_taken = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_SRC_WIDTH;
      csr_wdata = '0;
      hold_off_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      mismatch_count = 0;
      accepted_items = 0;
      pixels_checked = 0;
      quiet_cycles = 0;
      cur_width = 9'd256;
      cur_height = 9'd256;
      cur_x_step = 24'h010000;
      cur_y_step = 24'h010000;
      for (int i = 0; i < MAX_SRC_WIDTH*MAX_SRC_HEIGHT; i++) begin
         frame_copy[i] = '0;
         frame_written[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: the far corner of a full-size frame, extreme values, steps at reset
      pending_items.push_back('{FUNC_WRITE, 10'd0, 10'd0, 8'hff, 8'h00, 8'hff});
      pending_items.push_back('{FUNC_WRITE, 10'd1, 10'd0, 8'h00, 8'hff, 8'h00});
      pending_items.push_back('{FUNC_WRITE, 10'd0, 10'd1, 8'hff, 8'hff, 8'hff});
      pending_items.push_back('{FUNC_WRITE, 10'd1, 10'd1, 8'h00, 8'h00, 8'h00});
      pending_items.push_back('{FUNC_WRITE, 10'd255, 10'd255, 8'h5a, 8'ha5, 8'h3c});
      pending_items.push_back('{FUNC_WRITE, 10'd1023, 10'd1023, 8'h12, 8'h34, 8'h56});
      pending_items.push_back('{FUNC_WRITE, 10'd256, 10'd0, 8'h77, 8'h77, 8'h77});
      for (int i = 0; i < 4; i++) frame_written[(i/2)*MAX_SRC_WIDTH + i%2] = 1'b1;
      frame_written[255*MAX_SRC_WIDTH+255] = 1'b1;
      pending_items.push_back('{FUNC_REQUEST, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00});
      pending_items.push_back('{FUNC_REQUEST, 10'd1023, 10'd1023, 8'hff, 8'hff, 8'hff});
      pending_items.push_back('{FUNC_REQUEST, 10'd255, 10'd255, 8'h00, 8'h00, 8'h00});
      wait_idle();
      // half x step, near three-quarter y step on a 2x2 frame: fraction 128 and the edge clamp
      write_reg(REG_SRC_WIDTH, 24'd2);
      write_reg(REG_SRC_HEIGHT, 24'd2);
      write_reg(REG_X_STEP, 24'h008000);
      write_reg(REG_Y_STEP, 24'h00c0ff);
      for (int i = 0; i < 6; i++)
         pending_items.push_back('{FUNC_REQUEST, 10'(i), 10'(5 - i), 8'h00, 8'h00, 8'h00});
      pending_items.push_back('{FUNC_REQUEST, 10'd1023, 10'd1023, 8'h00, 8'h00, 8'h00});
      wait_idle();

      // random phases: sizes zero, small, full and oversized; steps zero to max
      run_phase(0, 0, 24'd0, 24'd0, 30, 0, 0);
      run_phase(5, 7, 24'h00b3a1, 24'h014321, 70, 0, 0);
      run_phase(511, 300, 24'hffffff, 24'h000001, 60, 75, 0);
      run_phase(12, 3, 24'($urandom_range(24'h03ffff, 0)), 24'($urandom_range(24'h03ffff, 0)),
                100, 0, 75);
      run_phase(256, 256, 24'h010000, 24'h00ffff, 70, 8, 8);
      run_phase(9, 12, 24'h00aaaa, 24'h005555, 90, 0, 0);
      // receiver holds off long while the sender keeps offering
      hold_off_cycles = 300;
      run_phase(11, 10, 24'h01ffff, 24'h00c000, 70, 0, 0);
      run_phase(1, 256, 24'h7fffff, 24'h00fedc, 50, 30, 30);

      $display("covered %0d accepted items, %0d pixels checked, %0d mismatches",
               accepted_items, pixels_checked, mismatch_count);
      $display("sizes 0..511, steps 0..max, idle and stall phases, one long hold-off");
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("bilinear_rgb_scaler_unit_tb passed");
      else
         $display("bilinear_rgb_scaler_unit_tb failed");
      $finish;
   end

endmodule
`default_nettype wire
